FILE: src/aepi_pkg.sv
// ----------------------------------------------------------------------------
// aepi_pkg
// Shared types and constants for the box pair impulse pipeline.
// ----------------------------------------------------------------------------
package aepi_pkg;

    // outcome of one pair test
    typedef enum logic [1:0] {
        ST_NO_OVERLAP = 2'd0,
        ST_RESOLVED   = 2'd1,
        ST_COINCIDENT = 2'd2,
        ST_SEPARATING = 2'd3
    } status_t;

    // control that travels with every request between pipeline parts
    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

    // velocity slots carried down the pipe
    localparam int NUM_VEL  = 4;
    localparam int VEL_A_X  = 0;
    localparam int VEL_A_Y  = 1;
    localparam int VEL_B_X  = 2;
    localparam int VEL_B_Y  = 3;

endpackage

FILE: src/aepi_front.sv
// ----------------------------------------------------------------------------
// aepi_front
// Overlap test, doubled center difference, relative velocity, normal dot
// product and squared distance over three register stages.
// ----------------------------------------------------------------------------
module aepi_front #(
    parameter int W = 32,
    localparam int DW   = W + 3,
    localparam int RW   = W + 1,
    localparam int KW   = RW + DW + 1,
    localparam int DENW = 2 * DW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] a_pos_x,
    input  logic signed [W-1:0] a_pos_y,
    input  logic [W-2:0]        a_size_x,
    input  logic [W-2:0]        a_size_y,
    input  logic signed [W-1:0] a_vel_x,
    input  logic signed [W-1:0] a_vel_y,
    input  logic signed [W-1:0] b_pos_x,
    input  logic signed [W-1:0] b_pos_y,
    input  logic [W-2:0]        b_size_x,
    input  logic [W-2:0]        b_size_y,
    input  logic signed [W-1:0] b_vel_x,
    input  logic signed [W-1:0] b_vel_y,
    output aepi_pkg::ctl_t      out_ctl,
    input  logic                out_ready,
    output logic signed [W-1:0] out_vel [aepi_pkg::NUM_VEL],
    output logic [KW-1:0]       out_k,
    output logic [DW-1:0]       out_dmag_x,
    output logic [DW-1:0]       out_dmag_y,
    output logic                out_dneg_x,
    output logic                out_dneg_y,
    output logic [DENW-1:0]     out_den
);

    // stage enables, back to front
    logic ld1, ld2, ld3;
    logic v1_reg, v2_reg, v3_reg;
    aepi_pkg::status_t st3_reg;

    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 1: extended operands
    logic signed [W+1:0] apx_e, apy_e, bpx_e, bpy_e;
    logic signed [W+1:0] asx_e, asy_e, bsx_e, bsy_e;
    logic signed [W+1:0] ca_x, ca_y, cb_x, cb_y;
    logic                ovl_next;
    logic signed [DW-1:0] dx_next, dy_next;
    logic signed [RW-1:0] rvx_next, rvy_next;

    assign apx_e = {{2{a_pos_x[W-1]}}, a_pos_x};
    assign apy_e = {{2{a_pos_y[W-1]}}, a_pos_y};
    assign bpx_e = {{2{b_pos_x[W-1]}}, b_pos_x};
    assign bpy_e = {{2{b_pos_y[W-1]}}, b_pos_y};
    assign asx_e = {3'b000, a_size_x};
    assign asy_e = {3'b000, a_size_y};
    assign bsx_e = {3'b000, b_size_x};
    assign bsy_e = {3'b000, b_size_y};

    // touching edges count as overlap
    assign ovl_next = (apx_e + asx_e >= bpx_e) && (apx_e <= bpx_e + bsx_e) &&
                      (apy_e + asy_e >= bpy_e) && (apy_e <= bpy_e + bsy_e);

    // doubled centers keep the half size exact
    assign ca_x = (apx_e <<< 1) + asx_e;
    assign ca_y = (apy_e <<< 1) + asy_e;
    assign cb_x = (bpx_e <<< 1) + bsx_e;
    assign cb_y = (bpy_e <<< 1) + bsy_e;
    assign dx_next = {ca_x[W+1], ca_x} - {cb_x[W+1], cb_x};
    assign dy_next = {ca_y[W+1], ca_y} - {cb_y[W+1], cb_y};
    assign rvx_next = {a_vel_x[W-1], a_vel_x} - {b_vel_x[W-1], b_vel_x};
    assign rvy_next = {a_vel_y[W-1], a_vel_y} - {b_vel_y[W-1], b_vel_y};

    logic                 ovl1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic signed [RW-1:0] rvx1_reg, rvy1_reg;
    logic signed [W-1:0]  vel1_reg [aepi_pkg::NUM_VEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ld1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            ovl1_reg <= ovl_next;
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            rvx1_reg <= rvx_next;
            rvy1_reg <= rvy_next;
            vel1_reg[aepi_pkg::VEL_A_X] <= a_vel_x;
            vel1_reg[aepi_pkg::VEL_A_Y] <= a_vel_y;
            vel1_reg[aepi_pkg::VEL_B_X] <= b_vel_x;
            vel1_reg[aepi_pkg::VEL_B_Y] <= b_vel_y;
        end
    end

    // stage 2: products
    logic signed [RW+DW-1:0] px_next, py_next;
    logic signed [2*DW-1:0]  sqx_next, sqy_next;

    assign px_next  = rvx1_reg * dx1_reg;
    assign py_next  = rvy1_reg * dy1_reg;
    assign sqx_next = dx1_reg * dx1_reg;
    assign sqy_next = dy1_reg * dy1_reg;

    logic                    ovl2_reg, coinc2_reg;
    logic signed [DW-1:0]    dx2_reg, dy2_reg;
    logic signed [RW+DW-1:0] px2_reg, py2_reg;
    logic signed [2*DW-1:0]  sqx2_reg, sqy2_reg;
    logic signed [W-1:0]     vel2_reg [aepi_pkg::NUM_VEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ld2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            ovl2_reg   <= ovl1_reg;
            coinc2_reg <= (dx1_reg == '0) && (dy1_reg == '0);
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            px2_reg    <= px_next;
            py2_reg    <= py_next;
            sqx2_reg   <= sqx_next;
            sqy2_reg   <= sqy_next;
            vel2_reg   <= vel1_reg;
        end
    end

    // stage 3: dot product, squared length, outcome
    logic signed [KW-1:0] dot;
    aepi_pkg::status_t    status_next;

    assign dot = {px2_reg[RW+DW-1], px2_reg} + {py2_reg[RW+DW-1], py2_reg};

    always_comb
    begin
        if (!ovl2_reg)
        begin
            status_next = aepi_pkg::ST_NO_OVERLAP;
        end
        else if (coinc2_reg)
        begin
            status_next = aepi_pkg::ST_COINCIDENT;
        end
        else if (!dot[KW-1] && (dot != '0))
        begin
            status_next = aepi_pkg::ST_SEPARATING;
        end
        else
        begin
            status_next = aepi_pkg::ST_RESOLVED;
        end
    end

    logic [KW-1:0]   k3_reg;
    logic [DW-1:0]   dmx3_reg, dmy3_reg;
    logic            dnx3_reg, dny3_reg;
    logic [DENW-1:0] den3_reg;
    logic signed [W-1:0] vel3_reg [aepi_pkg::NUM_VEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ld3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            st3_reg  <= status_next;
            k3_reg   <= KW'(-dot);
            dmx3_reg <= dx2_reg[DW-1] ? DW'(-dx2_reg) : DW'(dx2_reg);
            dmy3_reg <= dy2_reg[DW-1] ? DW'(-dy2_reg) : DW'(dy2_reg);
            dnx3_reg <= dx2_reg[DW-1];
            dny3_reg <= dy2_reg[DW-1];
            den3_reg <= DENW'(sqx2_reg) + DENW'(sqy2_reg);
            vel3_reg <= vel2_reg;
        end
    end

    assign out_ctl.valid  = v3_reg;
    assign out_ctl.status = st3_reg;
    assign out_vel    = vel3_reg;
    assign out_k      = k3_reg;
    assign out_dmag_x = dmx3_reg;
    assign out_dmag_y = dmy3_reg;
    assign out_dneg_x = dnx3_reg;
    assign out_dneg_y = dny3_reg;
    assign out_den    = den3_reg;

endmodule

FILE: src/aepi_numer.sv
// ----------------------------------------------------------------------------
// aepi_numer
// Impulse numerators k*|D| per axis, built from two partial products and
// summed one stage later.
// ----------------------------------------------------------------------------
module aepi_numer #(
    parameter int W = 32,
    localparam int DW   = W + 3,
    localparam int RW   = W + 1,
    localparam int KW   = RW + DW + 1,
    localparam int DENW = 2 * DW,
    localparam int NW   = KW + DW,
    localparam int KL   = (KW + 1) / 2,
    localparam int KH   = KW - KL
) (
    input  logic                clk,
    input  logic                rst_n,
    input  aepi_pkg::ctl_t      in_ctl,
    output logic                in_ready,
    input  logic signed [W-1:0] in_vel [aepi_pkg::NUM_VEL],
    input  logic [KW-1:0]       in_k,
    input  logic [DW-1:0]       in_dmag_x,
    input  logic [DW-1:0]       in_dmag_y,
    input  logic                in_dneg_x,
    input  logic                in_dneg_y,
    input  logic [DENW-1:0]     in_den,
    output aepi_pkg::ctl_t      out_ctl,
    input  logic                out_ready,
    output logic signed [W-1:0] out_vel [aepi_pkg::NUM_VEL],
    output logic [NW-1:0]       out_num_x,
    output logic [NW-1:0]       out_num_y,
    output logic                out_dneg_x,
    output logic                out_dneg_y,
    output logic [DENW-1:0]     out_den
);

    logic v4_reg, v5_reg;
    aepi_pkg::status_t st4_reg, st5_reg;
    logic ld4, ld5;

    assign ld5      = !v5_reg || out_ready;
    assign ld4      = !v4_reg || ld5;
    assign in_ready = ld4;

    // stage 4: low and high partial products
    logic [KL+DW-1:0] plx4_reg, ply4_reg;
    logic [KH+DW-1:0] phx4_reg, phy4_reg;
    logic             dnx4_reg, dny4_reg;
    logic [DENW-1:0]  den4_reg;
    logic signed [W-1:0] vel4_reg [aepi_pkg::NUM_VEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ld4)
        begin
            v4_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            st4_reg  <= in_ctl.status;
            plx4_reg <= (KL+DW)'(in_k[KL-1:0]) * (KL+DW)'(in_dmag_x);
            ply4_reg <= (KL+DW)'(in_k[KL-1:0]) * (KL+DW)'(in_dmag_y);
            phx4_reg <= (KH+DW)'(in_k[KW-1:KL]) * (KH+DW)'(in_dmag_x);
            phy4_reg <= (KH+DW)'(in_k[KW-1:KL]) * (KH+DW)'(in_dmag_y);
            dnx4_reg <= in_dneg_x;
            dny4_reg <= in_dneg_y;
            den4_reg <= in_den;
            vel4_reg <= in_vel;
        end
    end

    // stage 5: recombine partial products
    logic [NW-1:0]   nx5_reg, ny5_reg;
    logic            dnx5_reg, dny5_reg;
    logic [DENW-1:0] den5_reg;
    logic signed [W-1:0] vel5_reg [aepi_pkg::NUM_VEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (ld5)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            st5_reg  <= st4_reg;
            nx5_reg  <= {phx4_reg, {KL{1'b0}}} + NW'(plx4_reg);
            ny5_reg  <= {phy4_reg, {KL{1'b0}}} + NW'(ply4_reg);
            dnx5_reg <= dnx4_reg;
            dny5_reg <= dny4_reg;
            den5_reg <= den4_reg;
            vel5_reg <= vel4_reg;
        end
    end

    assign out_ctl.valid  = v5_reg;
    assign out_ctl.status = st5_reg;
    assign out_vel    = vel5_reg;
    assign out_num_x  = nx5_reg;
    assign out_num_y  = ny5_reg;
    assign out_dneg_x = dnx5_reg;
    assign out_dneg_y = dny5_reg;
    assign out_den    = den5_reg;

endmodule

FILE: src/aepi_div.sv
// ----------------------------------------------------------------------------
// aepi_div
// Pipelined restoring divider, one quotient bit per stage, both axes side by
// side against the shared squared length.
// ----------------------------------------------------------------------------
module aepi_div #(
    parameter int W = 32,
    localparam int DW   = W + 3,
    localparam int RW   = W + 1,
    localparam int KW   = RW + DW + 1,
    localparam int DENW = 2 * DW,
    localparam int NW   = KW + DW,
    localparam int QW   = W + 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  aepi_pkg::ctl_t      in_ctl,
    output logic                in_ready,
    input  logic signed [W-1:0] in_vel [aepi_pkg::NUM_VEL],
    input  logic [NW-1:0]       in_num_x,
    input  logic [NW-1:0]       in_num_y,
    input  logic                in_dneg_x,
    input  logic                in_dneg_y,
    input  logic [DENW-1:0]     in_den,
    output aepi_pkg::ctl_t      out_ctl,
    input  logic                out_ready,
    output logic signed [W-1:0] out_vel [aepi_pkg::NUM_VEL],
    output logic [QW-1:0]       out_q_x,
    output logic [QW-1:0]       out_q_y,
    output logic [DENW-1:0]     out_rem_x,
    output logic [DENW-1:0]     out_rem_y,
    output logic                out_dneg_x,
    output logic                out_dneg_y,
    output logic [DENW-1:0]     out_den
);

    logic [QW:0]         ld;
    logic                vld_reg [QW];
    aepi_pkg::status_t   st_reg  [QW];
    logic [NW-1:0]       rx_reg  [QW];
    logic [NW-1:0]       ry_reg  [QW];
    logic [QW-1:0]       qx_reg  [QW];
    logic [QW-1:0]       qy_reg  [QW];
    logic                dnx_reg [QW];
    logic                dny_reg [QW];
    logic [DENW-1:0]     den_reg [QW];
    logic signed [W-1:0] vel_reg [QW][aepi_pkg::NUM_VEL];

    assign ld[QW]   = out_ready;
    assign in_ready = ld[0];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int B = QW - 1 - j;

        logic                vld_in;
        aepi_pkg::status_t   st_in;
        logic [NW-1:0]       rx_in, ry_in;
        logic [QW-1:0]       qx_in, qy_in;
        logic                dnx_in, dny_in;
        logic [DENW-1:0]     den_in;
        logic signed [W-1:0] vel_in [aepi_pkg::NUM_VEL];
        logic [NW:0]         sh, tx, ty;

        if (j == 0)
        begin : g_first
            assign vld_in = in_ctl.valid;
            assign st_in  = in_ctl.status;
            assign rx_in  = in_num_x;
            assign ry_in  = in_num_y;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign dnx_in = in_dneg_x;
            assign dny_in = in_dneg_y;
            assign den_in = in_den;
            assign vel_in = in_vel;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[j-1];
            assign st_in  = st_reg[j-1];
            assign rx_in  = rx_reg[j-1];
            assign ry_in  = ry_reg[j-1];
            assign qx_in  = qx_reg[j-1];
            assign qy_in  = qy_reg[j-1];
            assign dnx_in = dnx_reg[j-1];
            assign dny_in = dny_reg[j-1];
            assign den_in = den_reg[j-1];
            assign vel_in = vel_reg[j-1];
        end

        // trial subtract of the shifted divisor
        assign sh = (NW+1)'(den_in) << B;
        assign tx = {1'b0, rx_in} - sh;
        assign ty = {1'b0, ry_in} - sh;

        assign ld[j] = !vld_reg[j] || ld[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (ld[j])
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[j])
            begin
                st_reg[j]  <= st_in;
                rx_reg[j]  <= tx[NW] ? rx_in : tx[NW-1:0];
                ry_reg[j]  <= ty[NW] ? ry_in : ty[NW-1:0];
                qx_reg[j]  <= qx_in | (QW'(!tx[NW]) << B);
                qy_reg[j]  <= qy_in | (QW'(!ty[NW]) << B);
                dnx_reg[j] <= dnx_in;
                dny_reg[j] <= dny_in;
                den_reg[j] <= den_in;
                vel_reg[j] <= vel_in;
            end
        end
    end

    assign out_ctl.valid  = vld_reg[QW-1];
    assign out_ctl.status = st_reg[QW-1];
    assign out_vel    = vel_reg[QW-1];
    assign out_q_x    = qx_reg[QW-1];
    assign out_q_y    = qy_reg[QW-1];
    assign out_rem_x  = rx_reg[QW-1][DENW-1:0];
    assign out_rem_y  = ry_reg[QW-1][DENW-1:0];
    assign out_dneg_x = dnx_reg[QW-1];
    assign out_dneg_y = dny_reg[QW-1];
    assign out_den    = den_reg[QW-1];

endmodule

FILE: src/aabb_pair_elastic_impulse_unit.sv
// ----------------------------------------------------------------------------
// aabb_pair_elastic_impulse_unit
// Equal-mass elastic impulse between two 2D axis-aligned boxes, one pair per
// request, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one box pair per clock while the result side keeps taking,
// and returns one result per pair in order: three stages form the overlap
// test, center difference, dot product and squared length, two stages build
// the impulse numerators from partial products, COORD_WIDTH + 2 stages run the
// divider one quotient bit per stage, and a final stage rounds, saturates and
// holds the result. Throughput is one pair per cycle as long as the result
// side keeps taking; each stage moves on its own, so bubbles close up while
// the output waits. There is no state between pairs and no clearing after
// reset.
module aabb_pair_elastic_impulse_unit #(
    parameter int COORD_WIDTH = 32,
    localparam int W      = COORD_WIDTH,
    localparam int DW     = W + 3,
    localparam int RW     = W + 1,
    localparam int KW     = RW + DW + 1,
    localparam int DENW   = 2 * DW,
    localparam int NW     = KW + DW,
    localparam int QW     = W + 2,
    localparam int SW     = QW + 3,
    localparam int IN_TW  = ((12 * W - 4 + 7) / 8) * 8,
    localparam int OUT_BW = 4 * W + 2,
    localparam int OUT_TW = ((OUT_BW + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // a_pos_x, a_pos_y, a_size_x, a_size_y, a_vel_x, a_vel_y,
    // b_pos_x, b_pos_y, b_size_x, b_size_y, b_vel_x, b_vel_y
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y, pair_status
    output logic [OUT_TW-1:0] m_tdata
);

    // request field offsets
    localparam int O_APX = 0;
    localparam int O_APY = W;
    localparam int O_ASX = 2 * W;
    localparam int O_ASY = 3 * W - 1;
    localparam int O_AVX = 4 * W - 2;
    localparam int O_AVY = 5 * W - 2;
    localparam int O_BPX = 6 * W - 2;
    localparam int O_BPY = 7 * W - 2;
    localparam int O_BSX = 8 * W - 2;
    localparam int O_BSY = 9 * W - 3;
    localparam int O_BVX = 10 * W - 4;
    localparam int O_BVY = 11 * W - 4;

    // front: geometry and products
    aepi_pkg::ctl_t      f_ctl;
    logic                f_ready;
    logic signed [W-1:0] f_vel [aepi_pkg::NUM_VEL];
    logic [KW-1:0]       f_k;
    logic [DW-1:0]       f_dmx, f_dmy;
    logic                f_dnx, f_dny;
    logic [DENW-1:0]     f_den;

    aepi_front #(.W(W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .a_pos_x    (s_tdata[O_APX +: W]),
        .a_pos_y    (s_tdata[O_APY +: W]),
        .a_size_x   (s_tdata[O_ASX +: W-1]),
        .a_size_y   (s_tdata[O_ASY +: W-1]),
        .a_vel_x    (s_tdata[O_AVX +: W]),
        .a_vel_y    (s_tdata[O_AVY +: W]),
        .b_pos_x    (s_tdata[O_BPX +: W]),
        .b_pos_y    (s_tdata[O_BPY +: W]),
        .b_size_x   (s_tdata[O_BSX +: W-1]),
        .b_size_y   (s_tdata[O_BSY +: W-1]),
        .b_vel_x    (s_tdata[O_BVX +: W]),
        .b_vel_y    (s_tdata[O_BVY +: W]),
        .out_ctl    (f_ctl),
        .out_ready  (f_ready),
        .out_vel    (f_vel),
        .out_k      (f_k),
        .out_dmag_x (f_dmx),
        .out_dmag_y (f_dmy),
        .out_dneg_x (f_dnx),
        .out_dneg_y (f_dny),
        .out_den    (f_den)
    );

    // numerators
    aepi_pkg::ctl_t      n_ctl;
    logic                n_ready;
    logic signed [W-1:0] n_vel [aepi_pkg::NUM_VEL];
    logic [NW-1:0]       n_nx, n_ny;
    logic                n_dnx, n_dny;
    logic [DENW-1:0]     n_den;

    aepi_numer #(.W(W)) u_numer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (f_ctl),
        .in_ready   (f_ready),
        .in_vel     (f_vel),
        .in_k       (f_k),
        .in_dmag_x  (f_dmx),
        .in_dmag_y  (f_dmy),
        .in_dneg_x  (f_dnx),
        .in_dneg_y  (f_dny),
        .in_den     (f_den),
        .out_ctl    (n_ctl),
        .out_ready  (n_ready),
        .out_vel    (n_vel),
        .out_num_x  (n_nx),
        .out_num_y  (n_ny),
        .out_dneg_x (n_dnx),
        .out_dneg_y (n_dny),
        .out_den    (n_den)
    );

    // divider
    aepi_pkg::ctl_t      d_ctl;
    logic                d_ready;
    logic signed [W-1:0] d_vel [aepi_pkg::NUM_VEL];
    logic [QW-1:0]       d_qx, d_qy;
    logic [DENW-1:0]     d_rx, d_ry;
    logic                d_dnx, d_dny;
    logic [DENW-1:0]     d_den;

    aepi_div #(.W(W)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (n_ctl),
        .in_ready   (n_ready),
        .in_vel     (n_vel),
        .in_num_x   (n_nx),
        .in_num_y   (n_ny),
        .in_dneg_x  (n_dnx),
        .in_dneg_y  (n_dny),
        .in_den     (n_den),
        .out_ctl    (d_ctl),
        .out_ready  (d_ready),
        .out_vel    (d_vel),
        .out_q_x    (d_qx),
        .out_q_y    (d_qy),
        .out_rem_x  (d_rx),
        .out_rem_y  (d_ry),
        .out_dneg_x (d_dnx),
        .out_dneg_y (d_dny),
        .out_den    (d_den)
    );

    // clamp to the coordinate range
    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if ((v[SW-1:W-1] == '0) || (v[SW-1:W-1] == '1))
        begin
            r = v[W-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    // round half away from zero, apply the normal direction
    logic [QW:0]          mag_x, mag_y;
    logic signed [QW+1:0] dlt_x, dlt_y;
    logic signed [W-1:0]  nax, nay, nbx, nby;

    assign mag_x = (QW+1)'(d_qx) +
                   (QW+1)'({d_rx, 1'b0} >= {1'b0, d_den});
    assign mag_y = (QW+1)'(d_qy) +
                   (QW+1)'({d_ry, 1'b0} >= {1'b0, d_den});
    assign dlt_x = d_dnx ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    assign dlt_y = d_dny ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});

    // velocities only change on a resolved pair
    always_comb
    begin
        nax = d_vel[aepi_pkg::VEL_A_X];
        nay = d_vel[aepi_pkg::VEL_A_Y];
        nbx = d_vel[aepi_pkg::VEL_B_X];
        nby = d_vel[aepi_pkg::VEL_B_Y];
        if (d_ctl.status == aepi_pkg::ST_RESOLVED)
        begin
            nax = sat_w(SW'(d_vel[aepi_pkg::VEL_A_X]) + SW'(dlt_x));
            nay = sat_w(SW'(d_vel[aepi_pkg::VEL_A_Y]) + SW'(dlt_y));
            nbx = sat_w(SW'(d_vel[aepi_pkg::VEL_B_X]) - SW'(dlt_x));
            nby = sat_w(SW'(d_vel[aepi_pkg::VEL_B_Y]) - SW'(dlt_y));
        end
    end

    // output register
    logic              m_valid_reg;
    logic [OUT_TW-1:0] m_data_reg;
    logic [OUT_TW-1:0] m_data_next;

    assign d_ready     = !m_valid_reg || m_tready;
    assign m_data_next = OUT_TW'({d_ctl.status, nby, nbx, nay, nax});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            m_valid_reg <= d_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // input only backs up when a result is waiting on the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // divider remainder always below the divisor on a resolved pair
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        (d_ctl.valid && d_ctl.status == aepi_pkg::ST_RESOLVED) |-> (d_rx < d_den))
        else $error("x remainder not reduced");

    a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
        (d_ctl.valid && d_ctl.status == aepi_pkg::ST_RESOLVED) |-> (d_ry < d_den))
        else $error("y remainder not reduced");

endmodule
